FILE: sv/rfhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhp_pkg: shared types and constants of the radio frame header parser
// Field widths, header bit positions, result kinds and the item and result
// structures passed between the pipeline stages.
// ----------------------------------------------------------------------------
package rfhp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned TYPE_W     = 6;
   localparam int unsigned ACK_W      = 2;
   localparam int unsigned DEVICE_W   = 16;
   localparam int unsigned SIG_W      = 32;
   localparam int unsigned CNT_W      = 2;
   localparam int unsigned RSP_DATA_W = 104;
   localparam int unsigned RSP_PAD_W  = 6;

   // Header byte layout
   localparam int unsigned HDR_EXT_BIT = 7;
   localparam int unsigned HDR_FWD_BIT = 6;

   // Extension byte layout
   localparam int unsigned EXT_UNICAST_BIT = 5;
   localparam int unsigned EXT_SIG_BIT     = 4;

   // Result kinds
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              end_of_frame;
   } rfhp_item_type;

   typedef struct packed {
      logic          valid;
      rfhp_item_type item;
   } rfhp_slot_type;

   typedef struct packed {
      logic                result_kind;
      logic                forward_flag;
      logic [TYPE_W-1:0]   frame_type;
      logic [BYTE_W-1:0]   source_maker;
      logic [DEVICE_W-1:0] source_device;
      logic [ACK_W-1:0]    ack_kind;
      logic [BYTE_W-1:0]   target_maker;
      logic [DEVICE_W-1:0] target_device;
      logic [SIG_W-1:0]    frame_signature;
      logic [BYTE_W-1:0]   payload_byte;
      logic                last_result;
      logic                truncated;
   } rfhp_result_type;

endpackage

FILE: sv/rfhp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhp_in_reg: input register
// Captures one received byte per cycle while the parser takes them; holds each
// until taken, and refills in the same cycle as the parser drains it.
// ----------------------------------------------------------------------------
module rfhp_in_reg
   import rfhp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  rfhp_item_type req_item,
   input  logic          take,
   output rfhp_slot_type slot
);

   logic          valid_ff;
   logic          valid_in;
   rfhp_item_type item_ff;
   logic          accept;

   // Accept when empty or when the held byte leaves this cycle
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.item  = item_ff;

endmodule

FILE: sv/rfhp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhp_parser: frame header parse state and result formation
// Holds the parse phase and captured header fields, updates them for the
// byte in the input register and forms at most one result for it.
// ----------------------------------------------------------------------------
module rfhp_parser
   import rfhp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  rfhp_slot_type   slot,
   input  logic            out_space,
   output logic            take,
   output logic            res_valid,
   output rfhp_result_type res
);

   typedef enum logic [2:0] {
      PH_HEADER     = 3'd0,
      PH_SRC_MAKER  = 3'd1,
      PH_SRC_DEVICE = 3'd2,
      PH_EXTENSION  = 3'd3,
      PH_DEST       = 3'd4,
      PH_SIGNATURE  = 3'd5,
      PH_PAYLOAD    = 3'd6
   } phase_type;

   phase_type           phase_ff, phase_in, step_phase;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [BYTE_W-1:0]   header_ff, header_in;
   logic [BYTE_W-1:0]   ext_ff, ext_in;
   logic [BYTE_W-1:0]   src_maker_ff, src_maker_in;
   logic [DEVICE_W-1:0] src_dev_ff, src_dev_in;
   logic [BYTE_W-1:0]   tgt_maker_ff, tgt_maker_in;
   logic [DEVICE_W-1:0] tgt_dev_ff, tgt_dev_in;
   logic [SIG_W-1:0]    sig_ff, sig_in;

   logic [BYTE_W-1:0]   b;
   logic                eof;
   logic                header_done;
   logic                payload_hit;
   logic                emit;
   rfhp_result_type     hdr_res;
   rfhp_result_type     res_in;

   assign b   = slot.item.frame_byte;
   assign eof = slot.item.end_of_frame;

   // Capture the byte into the field of the current phase
   always_comb begin
      count_in     = count_ff;
      header_in    = header_ff;
      ext_in       = ext_ff;
      src_maker_in = src_maker_ff;
      src_dev_in   = src_dev_ff;
      tgt_maker_in = tgt_maker_ff;
      tgt_dev_in   = tgt_dev_ff;
      sig_in       = sig_ff;
      step_phase   = phase_ff;
      header_done  = 1'b0;
      payload_hit  = 1'b0;
      unique case (phase_ff)
         PH_PAYLOAD: begin
            payload_hit = 1'b1;
         end
         PH_SRC_MAKER: begin
            src_maker_in = b;
            count_in     = '0;
            step_phase   = PH_SRC_DEVICE;
         end
         PH_SRC_DEVICE: begin
            if (count_ff == '0) begin
               src_dev_in = DEVICE_W'(b);
               count_in   = CNT_W'(1);
            end else begin
               src_dev_in = src_dev_ff | {b, {BYTE_W{1'b0}}};
               count_in   = '0;
               if (header_ff[HDR_EXT_BIT]) begin
                  step_phase = PH_EXTENSION;
               end else begin
                  header_done = 1'b1;
               end
            end
         end
         PH_EXTENSION: begin
            ext_in   = b;
            count_in = '0;
            if (b[EXT_UNICAST_BIT]) begin
               step_phase = PH_DEST;
            end else if (b[EXT_SIG_BIT]) begin
               step_phase = PH_SIGNATURE;
            end else begin
               header_done = 1'b1;
            end
         end
         PH_DEST: begin
            if (count_ff == '0) begin
               tgt_maker_in = b;
               count_in     = CNT_W'(1);
            end else if (count_ff == CNT_W'(1)) begin
               tgt_dev_in = DEVICE_W'(b);
               count_in   = CNT_W'(2);
            end else begin
               tgt_dev_in = tgt_dev_ff | {b, {BYTE_W{1'b0}}};
               count_in   = '0;
               if (ext_ff[EXT_SIG_BIT]) begin
                  step_phase = PH_SIGNATURE;
               end else begin
                  header_done = 1'b1;
               end
            end
         end
         PH_SIGNATURE: begin
            sig_in = sig_ff | (SIG_W'(b) << {count_ff, 3'b000});
            if (count_ff == {CNT_W{1'b1}}) begin
               count_in    = '0;
               header_done = 1'b1;
            end else begin
               count_in = CNT_W'(count_ff + CNT_W'(1));
            end
         end
         default: begin
            // Header byte starts a new frame and clears every held field
            header_in    = b;
            ext_in       = '0;
            src_maker_in = '0;
            src_dev_in   = '0;
            tgt_maker_in = '0;
            tgt_dev_in   = '0;
            sig_in       = '0;
            count_in     = '0;
            step_phase   = PH_SRC_MAKER;
         end
      endcase
   end

   // Header summary from the freshly updated fields
   always_comb begin
      hdr_res                 = '0;
      hdr_res.result_kind     = KIND_HEADER;
      hdr_res.forward_flag    = header_in[HDR_FWD_BIT];
      hdr_res.frame_type      = header_in[TYPE_W-1:0];
      hdr_res.source_maker    = src_maker_in;
      hdr_res.source_device   = src_dev_in;
      hdr_res.ack_kind        = header_in[HDR_EXT_BIT] ? ext_in[BYTE_W-1 -: ACK_W] : '0;
      hdr_res.target_maker    = tgt_maker_in;
      hdr_res.target_device   = tgt_dev_in;
      hdr_res.frame_signature = sig_in;
   end

   // Pick the result and the phase for the next byte
   always_comb begin
      res_in   = '0;
      emit     = 1'b0;
      phase_in = step_phase;
      if (payload_hit) begin
         emit                = 1'b1;
         res_in.result_kind  = KIND_PAYLOAD;
         res_in.payload_byte = b;
         res_in.last_result  = eof;
         if (eof) begin
            phase_in = PH_HEADER;
         end
      end else if (header_done) begin
         emit               = 1'b1;
         res_in             = hdr_res;
         res_in.last_result = eof;
         phase_in           = eof ? PH_HEADER : PH_PAYLOAD;
      end else if (eof) begin
         // Frame ended early: report what was captured
         emit               = 1'b1;
         res_in             = hdr_res;
         res_in.last_result = 1'b1;
         res_in.truncated   = 1'b1;
         phase_in           = PH_HEADER;
      end
   end

   // Advance unless a result is due and the output register has no space
   assign take      = slot.valid && (!emit || out_space);
   assign res_valid = take && emit;
   assign res       = res_in;

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         header_ff    <= '0;
         ext_ff       <= '0;
         src_maker_ff <= '0;
         src_dev_ff   <= '0;
         tgt_maker_ff <= '0;
         tgt_dev_ff   <= '0;
         sig_ff       <= '0;
      end else if (take) begin
         phase_ff     <= phase_in;
         count_ff     <= (eof && !payload_hit) ? '0 : count_in;
         header_ff    <= header_in;
         ext_ff       <= ext_in;
         src_maker_ff <= src_maker_in;
         src_dev_ff   <= src_dev_in;
         tgt_maker_ff <= tgt_maker_in;
         tgt_dev_ff   <= tgt_dev_in;
         sig_ff       <= sig_in;
      end
   end

`ifndef SYNTHESIS
   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      take && eof |=> phase_ff == PH_HEADER)
      else $error("final byte did not return the parser to the header phase");

   a_eof_gives_result: assert property (@(posedge clock) disable iff (reset)
      take && eof |-> res_valid && res.last_result)
      else $error("final byte taken without a last result");

   a_payload_not_truncated: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.result_kind == KIND_PAYLOAD |-> !res.truncated)
      else $error("payload result flagged as truncated");

   a_result_has_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_space)
      else $error("result produced while output register is full");
`endif

endmodule

FILE: sv/rfhp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfhp_out_reg: result register
// Holds one result until the downstream side takes it; loads a new result
// in the same cycle as the held one leaves.
// ----------------------------------------------------------------------------
module rfhp_out_reg
   import rfhp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   input  rfhp_result_type res,
   output logic            out_space,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output rfhp_result_type rsp_res
);

   logic            valid_ff;
   logic            valid_in;
   rfhp_result_type res_ff;

   assign out_space = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Hold the result through a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

FILE: sv/radio_frame_header_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_frame_header_parser_core: radio MAC frame header parser
// Parses a received frame byte by byte, gives one header summary when the
// header is complete (or truncated) and one result per payload byte.
//
//   channel | dir | tdata                      | tuser       | tlast
//   req_    | in  | frame_byte                 | -           | end_of_frame
//   rsp_    | out | header fields, payload     | result_kind | last_result
//
// One byte is accepted per cycle while results can move on rsp_; a byte is
// held in the input register and its result in the result register before
// the result is valid on rsp_.
// Synchronous reset returns the parser to the header phase and empties both
// registers. A stall on rsp_ holds the result register; bytes that give no
// result keep flowing, and req_tready drops only when a result cannot move.
// ----------------------------------------------------------------------------
module radio_frame_header_parser_core
   import rfhp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] frame_byte
   input  logic [BYTE_W-1:0]     req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] forward_flag, [6:1] frame_type, [14:7] source_maker,
   // [30:15] source_device, [32:31] ack_kind, [40:33] target_maker,
   // [56:41] target_device, [88:57] frame_signature, [96:89] payload_byte,
   // [97] truncated, [103:98] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] result_kind
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   rfhp_item_type   req_item;
   rfhp_slot_type   slot;
   logic            take;
   logic            out_space;
   logic            res_valid;
   rfhp_result_type res;
   rfhp_result_type rsp_res;

   assign req_item.frame_byte   = req_tdata;
   assign req_item.end_of_frame = req_tlast;

   rfhp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .slot       (slot)
   );

   rfhp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .slot      (slot),
      .out_space (out_space),
      .take      (take),
      .res_valid (res_valid),
      .res       (res)
   );

   rfhp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_space  (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   // Pack the result fields, first field lowest
   assign rsp_tdata = {
      {RSP_PAD_W{1'b0}},
      rsp_res.truncated,
      rsp_res.payload_byte,
      rsp_res.frame_signature,
      rsp_res.target_device,
      rsp_res.target_maker,
      rsp_res.ack_kind,
      rsp_res.source_device,
      rsp_res.source_maker,
      rsp_res.frame_type,
      rsp_res.forward_flag
   };
   assign rsp_tuser = rsp_res.result_kind;
   assign rsp_tlast = rsp_res.last_result;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for radio_frame_header_parser_core
// Feeds whole, truncated and header-only frames byte by byte, predicts the
// header summary and payload results from its own copy of the parse state,
// and checks every result transfer field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb
   import rfhp_pkg::*;
();

   localparam int unsigned RANDOM_BYTES = 1700;

   // Parser position within a frame
   typedef enum logic [2:0] {
      AT_HEADER,
      AT_SOURCE_MAKER,
      AT_SOURCE_ID,
      AT_EXTENSION,
      AT_TARGET,
      AT_SIGNATURE,
      AT_PAYLOAD
   } frame_pos_type;

   // Tracks the parse state of the frame in flight, holds the results that
   // the accepted bytes call for and checks the block's results against them
   class frame_parse_board_type;
      rfhp_result_type expected_results[$];
      int unsigned     failures;
      frame_pos_type   pos;
      logic [1:0]      byte_idx;
      logic [7:0]      hdr_byte;
      logic [7:0]      ext_byte;
      logic [7:0]      src_maker;
      logic [15:0]     src_device;
      logic [7:0]      dst_maker;
      logic [15:0]     dst_device;
      logic [31:0]     signature;

      function new();
         failures = 0;
         pos = AT_HEADER;
         byte_idx = '0;
         hdr_byte = '0;
         ext_byte = '0;
         src_maker = '0;
         src_device = '0;
         dst_maker = '0;
         dst_device = '0;
         signature = '0;
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      // Queue a header summary built from what has been captured so far
      function void push_summary(logic last, logic cut_short);
         rfhp_result_type r;
         r = '0;
         r.result_kind     = KIND_HEADER;
         r.forward_flag    = hdr_byte[HDR_FWD_BIT];
         r.frame_type      = hdr_byte[TYPE_W-1:0];
         r.source_maker    = src_maker;
         r.source_device   = src_device;
         r.ack_kind        = hdr_byte[HDR_EXT_BIT] ? ext_byte[7:6] : 2'b00;
         r.target_maker    = dst_maker;
         r.target_device   = dst_device;
         r.frame_signature = signature;
         r.last_result     = last;
         r.truncated       = cut_short;
         expected_results.push_back(r);
      endfunction

      // Advance the parse state by one accepted byte
      function void note_byte(logic [7:0] b, logic eof);
         frame_pos_type   nxt;
         rfhp_result_type r;
         nxt = pos;
         case (pos)
            AT_PAYLOAD: begin
               r = '0;
               r.result_kind  = KIND_PAYLOAD;
               r.payload_byte = b;
               r.last_result  = eof;
               expected_results.push_back(r);
               if (eof) pos = AT_HEADER;
               return;
            end
            AT_SOURCE_MAKER: begin
               src_maker = b;
               byte_idx = '0;
               nxt = AT_SOURCE_ID;
            end
            AT_SOURCE_ID: begin
               if (byte_idx == 2'd0) begin
                  src_device = {8'h00, b};
                  byte_idx = 2'd1;
               end else begin
                  src_device[15:8] = b;
                  byte_idx = '0;
                  nxt = hdr_byte[HDR_EXT_BIT] ? AT_EXTENSION : AT_PAYLOAD;
               end
            end
            AT_EXTENSION: begin
               ext_byte = b;
               byte_idx = '0;
               if (b[EXT_UNICAST_BIT]) nxt = AT_TARGET;
               else if (b[EXT_SIG_BIT]) nxt = AT_SIGNATURE;
               else nxt = AT_PAYLOAD;
            end
            AT_TARGET: begin
               if (byte_idx == 2'd0) begin
                  dst_maker = b;
                  byte_idx = 2'd1;
               end else if (byte_idx == 2'd1) begin
                  dst_device = {8'h00, b};
                  byte_idx = 2'd2;
               end else begin
                  dst_device[15:8] = b;
                  byte_idx = '0;
                  nxt = ext_byte[EXT_SIG_BIT] ? AT_SIGNATURE : AT_PAYLOAD;
               end
            end
            AT_SIGNATURE: begin
               signature = signature | (32'(b) << (8 * byte_idx));
               if (byte_idx == 2'd3) begin
                  byte_idx = '0;
                  nxt = AT_PAYLOAD;
               end else begin
                  byte_idx = byte_idx + 2'd1;
               end
            end
            default: begin
               // header byte starts a new frame and clears every held field
               hdr_byte = b;
               ext_byte = '0;
               src_maker = '0;
               src_device = '0;
               dst_maker = '0;
               dst_device = '0;
               signature = '0;
               byte_idx = '0;
               nxt = AT_SOURCE_MAKER;
            end
         endcase

         if (nxt == AT_PAYLOAD) begin
            push_summary(eof, 1'b0);
            pos = eof ? AT_HEADER : AT_PAYLOAD;
         end else if (eof) begin
            // frame ended before its header was complete
            push_summary(1'b1, 1'b1);
            pos = AT_HEADER;
            byte_idx = '0;
         end else begin
            pos = nxt;
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
         end
      endfunction

      // Check one result transfer against the oldest expectation
      function void check_result(logic kind, logic [RSP_DATA_W-1:0] data, logic last);
         rfhp_result_type want;
         if (expected_results.size() == 0) begin
            failures++;
            $display("%0t: result with none expected, expected nothing, actual kind %0b data %0h",
                     $time, kind, data);
            return;
         end
         want = expected_results.pop_front();
         compare_field("result_kind", 32'(want.result_kind), 32'(kind));
         compare_field("forward_flag", 32'(want.forward_flag), 32'(data[0]));
         compare_field("frame_type", 32'(want.frame_type), 32'(data[6:1]));
         compare_field("source_maker", 32'(want.source_maker), 32'(data[14:7]));
         compare_field("source_device", 32'(want.source_device), 32'(data[30:15]));
         compare_field("ack_kind", 32'(want.ack_kind), 32'(data[32:31]));
         compare_field("target_maker", 32'(want.target_maker), 32'(data[40:33]));
         compare_field("target_device", 32'(want.target_device), 32'(data[56:41]));
         compare_field("frame_signature", want.frame_signature, data[88:57]);
         compare_field("payload_byte", 32'(want.payload_byte), 32'(data[96:89]));
         compare_field("truncated", 32'(want.truncated), 32'(data[97]));
         compare_field("padding", 32'h0, 32'(data[103:98]));
         compare_field("last_result", 32'(want.last_result), 32'(last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   frame_parse_board_type parse_board;
   int unsigned           bytes_sent = 0;
   bit                    sender_idles = 1'b1;

   radio_frame_header_parser_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // Note accepted bytes first, then check results of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) parse_board.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) parse_board.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   // Receiver: random stalls, one long hold-off, one stretch always ready
   initial begin : receiver
      int unsigned cycle_count;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= 500 && cycle_count < 800) begin
            rsp_tready <= 1'b0;
         end else if (cycle_count >= 1300 && cycle_count < 1700) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 10);
         end
      end
   end

   // Offer one byte, idling at random first, and hold it until the transfer
   task automatic send_byte(input logic [7:0] b, input logic eof);
      if (sender_idles) begin
         while ($urandom_range(99) < 10) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom);
            req_tlast  <= 1'($urandom);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (parse_board.pending() != 0);
      @(posedge clock);
   endtask

   task automatic send_frame(input logic [7:0] frame_bytes[$]);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Random frame with a well-formed header; some are cut short in the header
   task automatic send_random_frame();
      logic [7:0]  hdr;
      logic [7:0]  ext;
      logic [7:0]  head_bytes[$];
      int unsigned payload_len;
      int unsigned total;
      int unsigned pick;
      hdr = 8'($urandom);
      ext = 8'($urandom);
      head_bytes = {hdr, 8'($urandom), 8'($urandom), 8'($urandom)};
      if (hdr[HDR_EXT_BIT]) begin
         head_bytes.push_back(ext);
         if (ext[EXT_UNICAST_BIT]) repeat (3) head_bytes.push_back(8'($urandom));
         if (ext[EXT_SIG_BIT]) repeat (4) head_bytes.push_back(8'($urandom));
      end
      pick = $urandom_range(99);
      if (pick < 10) payload_len = 0;
      else if (pick < 90) payload_len = $urandom_range(8, 1);
      else payload_len = $urandom_range(40, 9);
      if ($urandom_range(99) < 12) total = $urandom_range(head_bytes.size() - 1, 1);
      else total = head_bytes.size() + payload_len;
      for (int unsigned i = 0; i < total; i++) begin
         send_byte(i < head_bytes.size() ? head_bytes[i] : 8'($urandom), i == total - 1);
      end
   endtask

   initial begin : stimulus
      parse_board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain header with all-ones fields, payload extremes
      send_frame('{8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF});
      // extension with unicast and signature; header-only frame
      send_frame('{8'h80, 8'h00, 8'h34, 8'h12, 8'hF0, 8'hAB, 8'hCD, 8'hEF,
                   8'h01, 8'h02, 8'h03, 8'h04});
      // frame ends on its header byte
      send_frame('{8'hC5});
      // frame ends inside the signature
      send_frame('{8'h81, 8'h11, 8'h22, 8'h33, 8'h50, 8'hAA, 8'hBB});
      drain_results();

      while (bytes_sent < RANDOM_BYTES) begin
         sender_idles = !(bytes_sent >= 900 && bytes_sent < 1200);
         send_random_frame();
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (parse_board.failures == 0 && parse_board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Guard against a hang
   initial begin : watchdog
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
